@@ src/svarr_pkg.sv @@
// ---------------------------------------------------------------------------
// svarr_pkg: shared types and codes for the snapshot versioned array
// Request and result records, command codes and status codes.
// ---------------------------------------------------------------------------
package svarr_pkg;

	// command codes
	localparam logic [1:0] CMD_SET  = 2'd0;
	localparam logic [1:0] CMD_SNAP = 2'd1;
	localparam logic [1:0] CMD_GET  = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	// one accepted request
	typedef struct packed {
		logic [1:0]  command;
		logic [9:0]  cell_index;
		logic [31:0] write_value;
		logic [15:0] query_snapshot;
	} req_t;

	// one result, strobed for a single cycle
	typedef struct packed {
		logic        valid;
		logic [31:0] value;
		logic [1:0]  status;
	} res_t;

endpackage

@@ src/svarr_cnt_ram.sv @@
// ---------------------------------------------------------------------------
// svarr_cnt_ram: per-cell history count memory
// Synchronous single-port-read / single-port-write RAM with a clearing
// sweep after reset that zeroes one entry per cycle.
// ---------------------------------------------------------------------------
module svarr_cnt_ram #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	output logic              clearing,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

	logic [DATA_W-1:0] mem [DEPTH];
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [DATA_W-1:0] mem_data;

	assign clearing = clearing_q;

	// clear sweep overrides normal writes
	assign mem_we   = clearing_q | we;
	assign mem_addr = clearing_q ? clr_q : wr_addr;
	assign mem_data = clearing_q ? '0 : wr_data;

	// clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + ADDR_W'(1);
			if (clr_q == LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// memory array, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ src/svarr_hist_ram.sv @@
// ---------------------------------------------------------------------------
// svarr_hist_ram: history entry memory
// Synchronous RAM holding (snapshot id, value) pairs; one write and one
// enabled read per cycle, read data registered.
// ---------------------------------------------------------------------------
module svarr_hist_ram #(
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = 14,
	parameter int DATA_W = 48
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/svarr_ctrl.sv @@
// ---------------------------------------------------------------------------
// svarr_ctrl: command sequencer
// Holds the snapshot counter, reads a cell's count, then either checks the
// newest entry for a set or runs a binary search over the history for a get.
// ---------------------------------------------------------------------------
module svarr_ctrl #(
	parameter int ARRAY_LENGTH  = 1024,
	parameter int HISTORY_DEPTH = 16,
	parameter int SNAPSHOT_BITS = 16,
	parameter int CELL_W        = 10,
	parameter int CNT_W         = 5,
	parameter int ADDR_W        = 14,
	parameter int HE_W          = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              clearing,
	input  svarr_pkg::req_t   req,
	output logic              busy,
	output svarr_pkg::res_t   res,
	output logic [CELL_W-1:0] cnt_rd_addr,
	input  logic [CNT_W-1:0]  cnt_rd_data,
	output logic              cnt_we,
	output logic [CELL_W-1:0] cnt_wr_addr,
	output logic [CNT_W-1:0]  cnt_wr_data,
	output logic              hist_rd_en,
	output logic [ADDR_W-1:0] hist_rd_addr,
	input  logic [HE_W-1:0]   hist_rd_data,
	output logic              hist_we,
	output logic [ADDR_W-1:0] hist_wr_addr,
	output logic [HE_W-1:0]   hist_wr_data
);

	localparam int H_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [SNAPSHOT_BITS-1:0] SNAP_MAX = '1;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

	// sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_CNT    = 2'd1;
	localparam logic [1:0] S_SETCHK = 2'd2;
	localparam logic [1:0] S_SRCH   = 2'd3;

	logic [1:0]               state_q;
	logic [1:0]               cmd_q;
	logic [CELL_W-1:0]        cell_q;
	logic [31:0]              value_q;
	logic [15:0]              query_q;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;
	logic [H_W-1:0]           mid_q;
	logic [31:0]              best_q;
	logic [SNAPSHOT_BITS-1:0] cur_q;
	svarr_pkg::res_t          res_q;

	logic                     accept;
	logic                     in_range;
	logic [31:0]              cell_ext;
	logic [SNAPSHOT_BITS-1:0] rd_id;
	logic [31:0]              rd_val;
	logic                     id_le;
	logic                     id_hit;
	logic [CNT_W-1:0]         lo_nx;
	logic [CNT_W-1:0]         hi_nx;
	logic [H_W-1:0]           mid_nx;
	logic [H_W-1:0]           mid_first;
	logic [H_W-1:0]           k_rd;
	logic [H_W-1:0]           k_wr;
	logic                     set_full;

	assign busy   = clearing | (state_q != S_IDLE);
	assign accept = start & ~busy;
	assign res    = res_q;

	// cell address and range check
	assign cell_ext    = 32'(req.cell_index);
	assign in_range    = cell_ext < 32'(ARRAY_LENGTH);
	assign cnt_rd_addr = cell_ext[CELL_W-1:0];

	// history entry fields
	assign rd_id  = hist_rd_data[HE_W-1:32];
	assign rd_val = hist_rd_data[31:0];
	assign id_le  = 32'(rd_id) <= 32'(query_q);
	assign id_hit = rd_id == cur_q;

	// binary search step: keep [lo, hi) holding the answer boundary
	assign lo_nx     = id_le ? (CNT_W'(mid_q) + CNT_W'(1)) : lo_q;
	assign hi_nx     = id_le ? hi_q : CNT_W'(mid_q);
	assign mid_nx    = H_W'(({1'b0, lo_nx} + {1'b0, hi_nx}) >> 1);
	assign mid_first = H_W'({1'b0, cnt_rd_data} >> 1);

	// history read: newest entry for set, probe for get
	always_comb begin
		k_rd       = mid_nx;
		hist_rd_en = 1'b0;
		case (state_q)
			S_CNT: begin
				hist_rd_en = cnt_rd_data != '0;
				k_rd = (cmd_q == svarr_pkg::CMD_SET) ? H_W'(cnt_rd_data - CNT_W'(1))
				                                    : mid_first;
			end
			S_SRCH: begin
				hist_rd_en = lo_nx < hi_nx;
				k_rd       = mid_nx;
			end
			default: begin
				hist_rd_en = 1'b0;
			end
		endcase
	end
	assign hist_rd_addr = ADDR_W'(cell_q) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(k_rd);

	// history and count writes for set
	assign set_full = n_q >= DEPTH_CNT;
	always_comb begin
		hist_we     = 1'b0;
		cnt_we      = 1'b0;
		k_wr        = '0;
		cnt_wr_data = CNT_W'(1);
		case (state_q)
			S_CNT: begin
				if (cmd_q == svarr_pkg::CMD_SET && cnt_rd_data == '0) begin
					hist_we = 1'b1;
					cnt_we  = 1'b1;
				end
			end
			S_SETCHK: begin
				if (id_hit) begin
					hist_we = 1'b1;
					k_wr    = H_W'(n_q - CNT_W'(1));
				end else if (!set_full) begin
					hist_we     = 1'b1;
					cnt_we      = 1'b1;
					k_wr        = H_W'(n_q);
					cnt_wr_data = n_q + CNT_W'(1);
				end
			end
			default: begin
				hist_we = 1'b0;
			end
		endcase
	end
	assign cnt_wr_addr  = cell_q;
	assign hist_wr_addr = ADDR_W'(cell_q) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(k_wr);
	assign hist_wr_data = {cur_q, value_q};

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.command;
			cell_q  <= cell_ext[CELL_W-1:0];
			value_q <= req.write_value;
			query_q <= req.query_snapshot;
		end
	end

	// sequencer, snapshot counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			res_q   <= '0;
			n_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			best_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.command == svarr_pkg::CMD_SNAP) begin
							res_q <= '{valid: 1'b1, value: 32'(cur_q),
							           status: (cur_q == SNAP_MAX) ? svarr_pkg::STAT_SAT
							                                       : svarr_pkg::STAT_OK};
							if (cur_q != SNAP_MAX) begin
								cur_q <= cur_q + SNAPSHOT_BITS'(1);
							end
						end else if ((req.command == svarr_pkg::CMD_SET ||
						              req.command == svarr_pkg::CMD_GET) && in_range) begin
							res_q.valid <= 1'b0;
							state_q     <= S_CNT;
						end else begin
							res_q <= '{valid: 1'b1, value: 32'd0, status: svarr_pkg::STAT_OK};
						end
					end else begin
						res_q.valid <= 1'b0;
					end
				end
				S_CNT: begin
					n_q    <= cnt_rd_data;
					lo_q   <= '0;
					hi_q   <= cnt_rd_data;
					mid_q  <= mid_first;
					best_q <= 32'd0;
					if (cnt_rd_data == '0) begin
						res_q   <= '{valid: 1'b1, value: 32'd0, status: svarr_pkg::STAT_OK};
						state_q <= S_IDLE;
					end else if (cmd_q == svarr_pkg::CMD_SET) begin
						res_q.valid <= 1'b0;
						state_q     <= S_SETCHK;
					end else begin
						res_q.valid <= 1'b0;
						state_q     <= S_SRCH;
					end
				end
				S_SETCHK: begin
					res_q <= '{valid: 1'b1, value: 32'd0,
					           status: (!id_hit && set_full) ? svarr_pkg::STAT_FULL
					                                         : svarr_pkg::STAT_OK};
					state_q <= S_IDLE;
				end
				S_SRCH: begin
					lo_q  <= lo_nx;
					hi_q  <= hi_nx;
					mid_q <= mid_nx;
					if (id_le) begin
						best_q <= rd_val;
					end
					if (!(lo_nx < hi_nx)) begin
						res_q   <= '{valid: 1'b1, value: id_le ? rd_val : best_q,
						             status: svarr_pkg::STAT_OK};
						state_q <= S_IDLE;
					end else begin
						res_q.valid <= 1'b0;
					end
				end
				default: begin
					res_q.valid <= 1'b0;
					state_q     <= S_IDLE;
				end
			endcase
		end
	end

	// history writes come only from the set path
	assert property (@(posedge clk) disable iff (!arst_n)
		hist_we |-> (state_q == S_CNT || state_q == S_SETCHK))
		else $error("history write outside set path");

	// count never grows past the history depth
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (cnt_wr_data <= DEPTH_CNT && cnt_wr_data != '0))
		else $error("history count out of range");

	// search window is never empty while probing
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (lo_q < hi_q && CNT_W'(mid_q) < hi_q))
		else $error("search window collapsed");

	// snapshot counter never moves backward
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cur_q >= $past(cur_q))
		else $error("snapshot counter went backward");

	// no writes and no accepted requests while the count memory is being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!hist_we && !cnt_we && !accept))
		else $error("activity during clear sweep");

endmodule

@@ src/snapshot_versioned_array_top.sv @@
// ---------------------------------------------------------------------------
// snapshot_versioned_array_top: versioned array with per-cell history
// Each cell keeps (snapshot id, value) pairs; set, snap and get commands.
// ---------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. Its
//   fields are command, cell_index, write_value and query_snapshot.
//   Each request yields one result on result_value and status, shown for one
//   cycle with result_valid high. The receiver cannot stall the block.
// Sequence per command, one request at a time:
//   snap, unused command, cell out of range: result registered at accept.
//   set: count read, newest-entry read, write back; on an empty history the
//   write back comes with the count read.
//   get: count read, then a binary search of about log2(count)+1 probes,
//   one after another through the single read port of the history memory.
//   busy drops in the cycle of the strobe.
// Reset:
//   Asynchronous, active low. After release the count memory is swept to
//   zero, one cell per cycle, with busy held high.
//   The snapshot counter restarts at zero.
// ---------------------------------------------------------------------------
module snapshot_versioned_array_top #(
	parameter int ARRAY_LENGTH  = 1024,
	parameter int HISTORY_DEPTH = 16,
	parameter int SNAPSHOT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [9:0]  cell_index,
	input  logic [31:0] write_value,
	input  logic [15:0] query_snapshot,
	output logic        result_valid,
	output logic [31:0] result_value,
	output logic [1:0]  status
);

	localparam int CELL_W = (ARRAY_LENGTH > 1) ? $clog2(ARRAY_LENGTH) : 1;
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int HDEPTH = ARRAY_LENGTH * HISTORY_DEPTH;
	localparam int ADDR_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
	localparam int HE_W   = SNAPSHOT_BITS + 32;

	svarr_pkg::req_t   req;
	svarr_pkg::res_t   res;
	logic              clearing;
	logic [CELL_W-1:0] cnt_rd_addr;
	logic [CNT_W-1:0]  cnt_rd_data;
	logic              cnt_we;
	logic [CELL_W-1:0] cnt_wr_addr;
	logic [CNT_W-1:0]  cnt_wr_data;
	logic              hist_rd_en;
	logic [ADDR_W-1:0] hist_rd_addr;
	logic [HE_W-1:0]   hist_rd_data;
	logic              hist_we;
	logic [ADDR_W-1:0] hist_wr_addr;
	logic [HE_W-1:0]   hist_wr_data;

	// request bundle
	assign req = '{command: command, cell_index: cell_index,
	               write_value: write_value, query_snapshot: query_snapshot};

	// result ports
	assign result_valid = res.valid;
	assign result_value = res.value;
	assign status       = res.status;

	svarr_ctrl #(
		.ARRAY_LENGTH  (ARRAY_LENGTH),
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SNAPSHOT_BITS (SNAPSHOT_BITS),
		.CELL_W        (CELL_W),
		.CNT_W         (CNT_W),
		.ADDR_W        (ADDR_W),
		.HE_W          (HE_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.clearing     (clearing),
		.req          (req),
		.busy         (busy),
		.res          (res),
		.cnt_rd_addr  (cnt_rd_addr),
		.cnt_rd_data  (cnt_rd_data),
		.cnt_we       (cnt_we),
		.cnt_wr_addr  (cnt_wr_addr),
		.cnt_wr_data  (cnt_wr_data),
		.hist_rd_en   (hist_rd_en),
		.hist_rd_addr (hist_rd_addr),
		.hist_rd_data (hist_rd_data),
		.hist_we      (hist_we),
		.hist_wr_addr (hist_wr_addr),
		.hist_wr_data (hist_wr_data)
	);

	svarr_cnt_ram #(
		.DEPTH  (ARRAY_LENGTH),
		.ADDR_W (CELL_W),
		.DATA_W (CNT_W)
	) u_cnt_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.rd_addr  (cnt_rd_addr),
		.rd_data  (cnt_rd_data),
		.we       (cnt_we),
		.wr_addr  (cnt_wr_addr),
		.wr_data  (cnt_wr_data)
	);

	svarr_hist_ram #(
		.DEPTH  (HDEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (HE_W)
	) u_hist_ram (
		.clk     (clk),
		.rd_en   (hist_rd_en),
		.rd_addr (hist_rd_addr),
		.rd_data (hist_rd_data),
		.we      (hist_we),
		.wr_addr (hist_wr_addr),
		.wr_data (hist_wr_data)
	);

endmodule

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench for the snapshot versioned array
// Drives set, snap, get and unused-command requests through the start/busy
// handshake and predicts every result from a behavioral copy of the array
// kept in a small scoreboard. Directed corner cases come first, then random
// traffic built mostly from history-filling sequences on a few busy cells,
// then a short tail of mixed requests.
// ---------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CELLS      = 1024;
	localparam int         HIST_DEPTH = 16;
	localparam logic [15:0] SNAP_MAX  = 16'hFFFF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         RANDOM_ITEMS = 920;

	// one predicted result
	typedef struct {
		logic [31:0] value;
		logic [1:0]  status;
	} outcome_t;

	// behavioral copy of the array plus the queue of results still owed
	class array_scoreboard;
		logic [15:0] snap_ctr;
		logic [4:0]  hist_cnt [CELLS];
		logic [15:0] hist_id  [CELLS][HIST_DEPTH];
		logic [31:0] hist_val [CELLS][HIST_DEPTH];
		outcome_t    pending_outcomes [$];
		int          mismatches;

		function new();
			snap_ctr   = '0;
			mismatches = 0;
			foreach (hist_cnt[i])
				hist_cnt[i] = '0;
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction

		// apply one request to the array copy and return what it must answer
		function outcome_t apply_command(svarr_pkg::req_t r);
			outcome_t o;
			int       n;
			logic     found;
			o.value  = '0;
			o.status = svarr_pkg::STAT_OK;
			n        = int'(hist_cnt[r.cell_index]);
			found    = 1'b0;
			case (r.command)
			svarr_pkg::CMD_SET: begin
				// same id as the newest entry: overwrite, else append if room
				if (n > 0 && hist_id[r.cell_index][4'(n-1)] == snap_ctr) begin
					hist_val[r.cell_index][4'(n-1)] = r.write_value;
				end else if (n >= HIST_DEPTH) begin
					o.status = svarr_pkg::STAT_FULL;
				end else begin
					hist_id[r.cell_index][4'(n)]  = snap_ctr;
					hist_val[r.cell_index][4'(n)] = r.write_value;
					hist_cnt[r.cell_index]        = 5'(n + 1);
				end
			end
			svarr_pkg::CMD_SNAP: begin
				o.value = {16'd0, snap_ctr};
				if (snap_ctr == SNAP_MAX)
					o.status = svarr_pkg::STAT_SAT;
				else
					snap_ctr = snap_ctr + 16'd1;
			end
			svarr_pkg::CMD_GET: begin
				// newest entry whose id does not exceed the query
				for (int k = n - 1; k >= 0; k--) begin
					if (!found && hist_id[r.cell_index][4'(k)] <= r.query_snapshot) begin
						o.value = hist_val[r.cell_index][4'(k)];
						found   = 1'b1;
					end
				end
			end
			default: ;
			endcase
			return o;
		endfunction

		function void note_request(svarr_pkg::req_t r);
			pending_outcomes.insert(pending_outcomes.size(), apply_command(r));
		endfunction

		function void check_result(logic [31:0] value, logic [1:0] stat);
			outcome_t want;
			if (pending_outcomes.size() == 0) begin
				$error("unexpected result: value %h status %0d", value, stat);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				if (value !== want.value) begin
					$error("result_value: expected %h, got %h", want.value, value);
					mismatches++;
				end
				if (stat !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, stat);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        start          = 1'b0;
	logic [1:0]  command        = svarr_pkg::CMD_SET;
	logic [9:0]  cell_index     = '0;
	logic [31:0] write_value    = '0;
	logic [15:0] query_snapshot = '0;
	logic        busy;
	logic        result_valid;
	logic [31:0] result_value;
	logic [1:0]  status;

	array_scoreboard sb;
	int          idle_pct = 32;
	int          sent     = 0;
	logic [9:0]  hot_cells [8];

	snapshot_versioned_array_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.cell_index     (cell_index),
		.write_value    (write_value),
		.query_snapshot (query_snapshot),
		.result_valid   (result_valid),
		.result_value   (result_value),
		.status         (status)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// results are strobed for one cycle and taken at the edge ending it
	always @(posedge clk) begin
		if (result_valid === 1'b1)
			sb.check_result(result_value, status);
	end

	// issue one request; called at a rising edge, returns at its accept edge
	task automatic send_request(input logic [1:0] cmd, input logic [9:0] cell_idx,
		input logic [31:0] value, input logic [15:0] query);
		int              gap;
		svarr_pkg::req_t r;
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = $urandom_range(8, 1);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		command        <= cmd;
		cell_index     <= cell_idx;
		write_value    <= value;
		query_snapshot <= query;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		r.command        = cmd;
		r.cell_index     = cell_idx;
		r.write_value    = value;
		r.query_snapshot = query;
		sb.note_request(r);
		sent++;
	endtask

	// hold off until every outstanding request has answered
	task automatic wait_drained();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// query mostly near the ids handed out so far, sometimes anywhere
	function automatic logic [15:0] pick_query();
		int p;
		p = $urandom_range(99);
		if (p < 70)
			return 16'($urandom_range(int'(sb.snap_ctr) + 1));
		else if (p < 85)
			return SNAP_MAX;
		else
			return 16'($urandom_range(16'hFFFF));
	endfunction

	function automatic logic [9:0] pick_cell();
		if ($urandom_range(99) < 70)
			return hot_cells[3'($urandom_range(7))];
		else
			return 10'($urandom_range(CELLS - 1));
	endfunction

	task automatic send_random_item();
		int         p;
		logic [1:0] cmd;
		p = $urandom_range(99);
		if (p < 40)
			cmd = svarr_pkg::CMD_SET;
		else if (p < 62)
			cmd = svarr_pkg::CMD_SNAP;
		else if (p < 95)
			cmd = svarr_pkg::CMD_GET;
		else
			cmd = CMD_UNUSED;
		send_request(cmd, pick_cell(), $urandom, pick_query());
	endtask

	// alternate sets and snaps on one cell until its history overflows, then get it three times
	task automatic fill_history(input logic [9:0] cell_idx);
		repeat (HIST_DEPTH + 1) begin
			send_request(svarr_pkg::CMD_SET, cell_idx, $urandom, pick_query());
			if ($urandom_range(3) == 0)
				send_request(svarr_pkg::CMD_SET, cell_idx, $urandom, pick_query());
			send_request(svarr_pkg::CMD_SNAP, pick_cell(), $urandom, pick_query());
		end
		repeat (3)
			send_request(svarr_pkg::CMD_GET, cell_idx, $urandom, pick_query());
	endtask

	initial begin
		int random_goal;
		sb = new();
		foreach (hot_cells[i])
			hot_cells[i] = 10'($urandom_range(CELLS - 1));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty reads, overwrite, append, id boundaries, extremes
		send_request(svarr_pkg::CMD_GET,  10'd0,    32'h0000_0000, 16'h0000);
		send_request(svarr_pkg::CMD_SET,  10'd0,    32'hFFFF_FFFF, 16'h0000);
		send_request(svarr_pkg::CMD_SET,  10'd0,    32'hA5A5_A5A5, 16'hFFFF);
		send_request(svarr_pkg::CMD_GET,  10'd0,    32'hFFFF_FFFF, 16'h0000);
		send_request(svarr_pkg::CMD_SET,  10'd1023, 32'h0000_0000, 16'h0000);
		send_request(svarr_pkg::CMD_GET,  10'd1023, 32'h0000_0000, 16'hFFFF);
		send_request(svarr_pkg::CMD_SNAP, 10'd1023, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(svarr_pkg::CMD_SNAP, 10'd0,    32'h0000_0000, 16'h0000);
		send_request(svarr_pkg::CMD_SET,  10'd0,    32'h5A5A_5A5A, 16'h0000);
		send_request(svarr_pkg::CMD_GET,  10'd0,    32'h0000_0000, 16'h0001);
		send_request(svarr_pkg::CMD_GET,  10'd0,    32'h0000_0000, 16'h0002);
		send_request(svarr_pkg::CMD_GET,  10'd0,    32'h0000_0000, 16'hFFFF);
		send_request(svarr_pkg::CMD_GET,  10'd1023, 32'hFFFF_FFFF, 16'h0000);
		send_request(svarr_pkg::CMD_GET,  10'd512,  32'h0000_0000, 16'hFFFF);
		send_request(CMD_UNUSED,          10'd1023, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(CMD_UNUSED,          10'd0,    32'h0000_0000, 16'h0000);
		send_request(svarr_pkg::CMD_GET,  10'd0,    32'h0000_0000, 16'h0000);
		wait_drained();

		// random: mostly history-filling sequences, the rest loose requests
		random_goal = sent + RANDOM_ITEMS;
		fill_history(hot_cells[0]);
		while (sent < random_goal) begin
			idle_pct = (sent > random_goal - 450 && sent < random_goal - 200) ? 0 : 32;
			if ($urandom_range(99) < 4)
				fill_history(hot_cells[3'($urandom_range(7))]);
			else
				send_random_item();
		end
		idle_pct = 32;
		wait_drained();

		// tail: a few snaps, one more history fill, loose requests
		repeat (3)
			send_request(svarr_pkg::CMD_SNAP, pick_cell(), $urandom, pick_query());
		fill_history(10'($urandom_range(CELLS - 1)));
		repeat (60)
			send_random_item();
		start <= 1'b0;

		// let the last results come in, then check that none is still owed
		for (int n = 0; n < 1000 && sb.pending() != 0; n++)
			@(negedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (sb.pending() != 0) begin
			$error("%0d results never arrived", sb.pending());
			sb.mismatches++;
		end
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#(30_000_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
src/svarr_pkg.sv
src/svarr_cnt_ram.sv
src/svarr_hist_ram.sv
src/svarr_ctrl.sv
src/snapshot_versioned_array_top.sv
tb/sv/tb_top.sv
